### sv/xcfd_pkg.sv
package xcfd_pkg;

  // largest payload the design ever accepts, whatever the register says
  localparam int unsigned MaxPayloadBytes = 512;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_FLAGS   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_CMD     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4,
    EV_LONG    = 3'd5,
    EV_TIMEOUT = 3'd6
  } event_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  frame_flags;
    logic [15:0] frame_length;
    logic [7:0]  frame_command;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [9:0]  max_payload;
    logic [15:0] timeout_ticks;
  } cfg_t;

  localparam logic [9:0] MaxPayloadCap = 10'(MaxPayloadBytes);

endpackage

### sv/xor_checked_frame_deframer.sv
// Receive deframer for a byte-serial link with an XOR check byte.
// Input channel (in_valid_i/in_ready_o/in_data_i): each item is either a
// received byte or one time tick. Output channel (out_valid_o/out_ready_i/
// out_data_o): exactly one result item per input item, carrying the event
// code, the held header fields and, for payload bytes, the byte and index.
// The result of an item accepted at one edge is registered and valid
// after that edge. Throughput is one item per cycle while out_ready_i
// stays high, set by the single result register; the parser state
// updates in the same cycle. On a receiver stall the result register
// holds its item; with in_ready_o low no input is taken until delivery.
// Configuration is a plain write port (cfg_wr_en_i, cfg_idx_i,
// cfg_wdata_i): index 0 start byte, 1 max payload, 2 timeout ticks; other
// indexes are ignored. Write only while the block is idle.
// Reset (rst_ni low, asynchronous) empties the result register, returns
// the parser to hunting for the start byte and loads the register
// defaults: start byte 0, max payload 512, timeout 100 ticks.
module xor_checked_frame_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  xcfd_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output xcfd_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_wr_en_i,
  input  logic [xcfd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [xcfd_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  xcfd_pkg::cfg_t      cfg_q;
  xcfd_pkg::out_item_t res;
  logic                free;
  logic                step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= 8'd0;
      cfg_q.max_payload   <= 10'd512;
      cfg_q.timeout_ticks <= 16'd100;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_idx_i)
        xcfd_pkg::CFG_START_BYTE:    cfg_q.start_byte    <= cfg_wdata_i[7:0];
        xcfd_pkg::CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_wdata_i[9:0];
        xcfd_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_ready_o = free;
  assign step       = in_valid_i && free;

  xcfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  xcfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .free_o      (free)
  );

endmodule

### sv/xcfd_parser.sv
module xcfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  xcfd_pkg::in_item_t  item_i,
  input  xcfd_pkg::cfg_t      cfg_i,
  output xcfd_pkg::out_item_t res_o
);

  xcfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  command_q, command_d;
  logic [9:0]  count_q, count_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] idle_q, idle_d;

  xcfd_pkg::event_e ev;
  logic [7:0]  pbyte;
  logic [8:0]  pindex;
  logic        abort;
  logic [7:0]  b;
  logic [15:0] len_new;
  logic [9:0]  limit;
  logic        in_frame;

  assign b = item_i.data_byte;
  assign len_new = {b, length_q[7:0]};
  assign limit = (cfg_i.max_payload < xcfd_pkg::MaxPayloadCap) ? cfg_i.max_payload
                                                               : xcfd_pkg::MaxPayloadCap;
  assign in_frame = (phase_q == xcfd_pkg::PH_FLAGS) || (phase_q == xcfd_pkg::PH_LEN_LO) ||
                    (phase_q == xcfd_pkg::PH_LEN_HI) || (phase_q == xcfd_pkg::PH_CMD) ||
                    (phase_q == xcfd_pkg::PH_PAYLOAD) || (phase_q == xcfd_pkg::PH_CHECK);

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= xcfd_pkg::PH_HUNT;
      flags_q   <= '0;
      length_q  <= '0;
      command_q <= '0;
      count_q   <= '0;
      xor_q     <= '0;
      idle_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      flags_q   <= flags_d;
      length_q  <= length_d;
      command_q <= command_d;
      count_q   <= count_d;
      xor_q     <= xor_d;
      idle_q    <= idle_d;
    end
  end

  // next state and result for one item
  always_comb begin
    phase_d   = phase_q;
    flags_d   = flags_q;
    length_d  = length_q;
    command_d = command_q;
    count_d   = count_q;
    xor_d     = xor_q;
    idle_d    = idle_q;
    ev        = xcfd_pkg::EV_NONE;
    pbyte     = '0;
    pindex    = '0;
    abort     = 1'b0;

    if (item_i.op == xcfd_pkg::OP_TICK) begin
      // idle time inside a frame; once the count reaches the timeout, the frame is aborted
      if (in_frame) begin
        if (idle_q >= cfg_i.timeout_ticks) begin
          ev    = xcfd_pkg::EV_TIMEOUT;
          abort = 1'b1;
        end else begin
          idle_d = idle_q + 16'd1;
        end
      end
    end else begin
      idle_d = '0;
      unique case (phase_q)
        xcfd_pkg::PH_FLAGS: begin
          flags_d = b;
          xor_d   = xor_q ^ b;
          phase_d = xcfd_pkg::PH_LEN_LO;
          ev      = xcfd_pkg::EV_HEADER;
        end
        xcfd_pkg::PH_LEN_LO: begin
          length_d = {8'd0, b};
          xor_d    = xor_q ^ b;
          phase_d  = xcfd_pkg::PH_LEN_HI;
          ev       = xcfd_pkg::EV_HEADER;
        end
        xcfd_pkg::PH_LEN_HI: begin
          length_d = len_new;
          xor_d    = xor_q ^ b;
          if (len_new > {6'd0, limit}) begin
            ev    = xcfd_pkg::EV_LONG;
            abort = 1'b1;
          end else begin
            phase_d = xcfd_pkg::PH_CMD;
            ev      = xcfd_pkg::EV_HEADER;
          end
        end
        xcfd_pkg::PH_CMD: begin
          command_d = b;
          xor_d     = xor_q ^ b;
          count_d   = '0;
          phase_d   = (length_q != 16'd0) ? xcfd_pkg::PH_PAYLOAD : xcfd_pkg::PH_CHECK;
          ev        = xcfd_pkg::EV_HEADER;
        end
        xcfd_pkg::PH_PAYLOAD: begin
          pbyte   = b;
          pindex  = count_q[8:0];
          xor_d   = xor_q ^ b;
          count_d = count_q + 10'd1;
          if ({6'd0, count_d} >= length_q) begin
            phase_d = xcfd_pkg::PH_CHECK;
          end
          ev = xcfd_pkg::EV_PAYLOAD;
        end
        xcfd_pkg::PH_CHECK: begin
          ev      = (xor_q == b) ? xcfd_pkg::EV_GOOD : xcfd_pkg::EV_BAD;
          phase_d = xcfd_pkg::PH_HUNT;
        end
        default: begin
          // hunting, an unused phase code hunts too
          phase_d = xcfd_pkg::PH_HUNT;
          if (b == cfg_i.start_byte) begin
            flags_d   = '0;
            length_d  = '0;
            command_d = '0;
            count_d   = '0;
            xor_d     = '0;
            phase_d   = xcfd_pkg::PH_FLAGS;
            ev        = xcfd_pkg::EV_HEADER;
          end
        end
      endcase
    end

    // result shows header fields before an abort clears them
    res_o.event_res     = ev;
    res_o.frame_flags   = flags_d;
    res_o.frame_length  = length_d;
    res_o.frame_command = command_d;
    res_o.payload_byte  = pbyte;
    res_o.payload_index = pindex;

    if (abort) begin
      phase_d   = xcfd_pkg::PH_HUNT;
      flags_d   = '0;
      length_d  = '0;
      command_d = '0;
      count_d   = '0;
      xor_d     = '0;
      idle_d    = '0;
    end
  end

endmodule

### sv/xcfd_out_reg.sv
module xcfd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  xcfd_pkg::out_item_t res_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output xcfd_pkg::out_item_t out_data_o,
  output logic                free_o
);

  logic                valid_q;
  xcfd_pkg::out_item_t data_q;

  // register is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
